>>> rtl/dttc_pkg.sv
// ----------------------------------------------------------------------------
// dttc_pkg
// Shared constants for the decimal text to cents parser: character codes,
// the integer part limit and the result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dttc_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;

  // Largest integer part whose value in hundredths still fits a signed 64-bit word.
  localparam logic [63:0] INT_PART_LIMIT  = 64'd92233720368547758;
  localparam logic [6:0]  CENTS_LIMIT_REM = 7'd7;

  localparam int unsigned AMOUNT_W = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_W    = 72;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FORMAT    = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNUSED    = 2'd3
  } status_t;

endpackage

`default_nettype wire

>>> rtl/decimal_text_to_cents_parser.sv
// ----------------------------------------------------------------------------
// decimal_text_to_cents_parser
// Parses a decimal money string, one byte per request, into a signed amount
// in hundredths with a status.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one text byte per request in s_tdata. s_tuser
//   marks a request that carries no character, used to close an empty
//   string. s_tlast ends the string; that request yields one result on the
//   master channel, all other requests yield none.
//   The master channel carries the amount in hundredths (bits 63:0) and the
//   status (bits 65:64: ok, format error, overflow). The amount is zero
//   whenever the status is not ok.
//   Throughput is one request per cycle unless a closing request waits for
//   the result register. A request is held in an input register and then
//   folded into the string state; the result register is loaded at that
//   point, so m_tvalid rises once the closing request leaves the input
//   register. The integer part's multiply-by-ten accumulate sets the cycle.
//   When the receiver stalls with a result waiting, requests that do not
//   close a string keep flowing; a closing request waits in the input
//   register until the result register frees, and s_tready drops meanwhile.
//   Reset clears the string state and the valid flags of both registers; no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_cents_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tuser,   // [0] no_char
  input  wire logic        s_tlast,   // last_char
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [dttc_pkg::OUT_W-1:0] m_tdata  // [63:0] amount_cents, [65:64] status
);
  import dttc_pkg::*;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_INT   = 2'd1,
    PH_FRAC  = 2'd2
  } phase_t;

  logic        in_vld;
  logic [7:0]  in_char;
  logic        in_none;
  logic        in_last;

  phase_t             phase;
  logic               negative;
  logic [63:0]        mag;
  logic signed [63:0] cents_base;
  logic               int_seen;
  logic [6:0]         frac;
  logic [1:0]         fcnt;
  logic               ferr;
  logic               ovf;

  phase_t             phase_next;
  logic               negative_next;
  logic [63:0]        mag_next;
  logic signed [63:0] cents_base_next;
  logic               int_seen_next;
  logic [6:0]         frac_next;
  logic [1:0]         fcnt_next;
  logic               ferr_next;
  logic               ovf_next;

  logic               at_start;
  logic               is_digit;
  logic               int_digit;
  logic [3:0]         digit;
  logic [63:0]        digit_cents;
  logic signed [63:0] frac_signed;
  logic signed [63:0] amount;
  logic               fin_ferr;
  logic               fin_ovf;
  status_t            status;
  logic               advance;

  assign advance  = in_vld && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_vld || advance;

  assign at_start    = (phase == PH_START);
  assign is_digit    = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
  assign digit       = in_char[3:0];
  assign digit_cents = 64'(digit) * 64'd100;
  assign int_digit   = !in_none && is_digit && (at_start || phase == PH_INT) && !ovf;

  always_comb begin
    phase_next      = phase;
    negative_next   = negative;
    mag_next        = mag;
    cents_base_next = cents_base;
    int_seen_next   = int_seen;
    frac_next       = frac;
    fcnt_next       = fcnt;
    ferr_next       = ferr;
    ovf_next        = ovf;
    if (!in_none) begin
      if (at_start) begin
        phase_next = PH_INT;
      end
      if (is_digit) begin
        if (at_start || phase == PH_INT) begin
          int_seen_next = 1'b1;
          if (!ovf) begin
            mag_next        = (mag << 3) + (mag << 1) + 64'(digit);
            cents_base_next = (cents_base <<< 3) + (cents_base <<< 1) +
                              (negative ? -$signed(digit_cents) : $signed(digit_cents));
            ovf_next        = (mag_next > INT_PART_LIMIT);
          end
        end else begin
          unique case (fcnt)
            2'd0: begin
              frac_next = 7'(digit) * 7'd10;
              fcnt_next = 2'd1;
            end
            2'd1: begin
              frac_next = frac + 7'(digit);
              fcnt_next = 2'd2;
            end
            default: begin
              ferr_next = 1'b1;
            end
          endcase
        end
      end else if (in_char == CHAR_MINUS && at_start) begin
        negative_next = 1'b1;
      end else if (in_char == CHAR_POINT && (at_start || phase == PH_INT)) begin
        phase_next = PH_FRAC;
      end else begin
        ferr_next = 1'b1;
      end
    end
  end

  always_comb begin
    fin_ferr = ferr_next;
    if (phase_next == PH_START) begin
      fin_ferr = 1'b1;
    end else if (!int_seen_next && (phase_next != PH_FRAC || fcnt_next == 2'd0)) begin
      fin_ferr = 1'b1;
    end
    fin_ovf = ovf_next ||
              (!fin_ferr && mag_next == INT_PART_LIMIT && frac_next > CENTS_LIMIT_REM);
    frac_signed = negative_next ? -$signed({57'd0, frac_next}) : $signed({57'd0, frac_next});
    amount      = int_digit ? cents_base_next : cents_base + frac_signed;
    priority if (fin_ferr) begin
      status = ST_FORMAT;
    end else if (fin_ovf) begin
      status = ST_OVERFLOW;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld     <= 1'b0;
      m_tvalid   <= 1'b0;
      phase      <= PH_START;
      negative   <= 1'b0;
      mag        <= '0;
      cents_base <= '0;
      int_seen   <= 1'b0;
      frac       <= '0;
      fcnt       <= '0;
      ferr       <= 1'b0;
      ovf        <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_vld  <= 1'b1;
        in_char <= s_tdata;
        in_none <= s_tuser;
        in_last <= s_tlast;
      end else if (advance) begin
        in_vld <= 1'b0;
      end
      if (m_tvalid && m_tready && !(advance && in_last)) begin
        m_tvalid <= 1'b0;
      end
      if (advance) begin
        if (in_last) begin
          m_tvalid   <= 1'b1;
          m_tdata    <= {6'd0, status, (status == ST_OK) ? amount : 64'sd0};
          phase      <= PH_START;
          negative   <= 1'b0;
          mag        <= '0;
          cents_base <= '0;
          int_seen   <= 1'b0;
          frac       <= '0;
          fcnt       <= '0;
          ferr       <= 1'b0;
          ovf        <= 1'b0;
        end else begin
          phase      <= phase_next;
          negative   <= negative_next;
          mag        <= mag_next;
          cents_base <= cents_base_next;
          int_seen   <= int_seen_next;
          frac       <= frac_next;
          fcnt       <= fcnt_next;
          ferr       <= ferr_next;
          ovf        <= ovf_next;
        end
      end
    end
  end

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[65:64] != ST_UNUSED)
    else $error("result carries an undefined status code");

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[65:64] != ST_OK) |-> m_tdata[63:0] == 64'd0)
    else $error("failed parse carries a nonzero amount");

  a_clear_after_close: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (phase == PH_START && !ferr && !ovf && mag == 64'd0))
    else $error("string state not cleared after a result");

  a_ovf_means_large: assert property (@(posedge clk) disable iff (rst)
    ovf |-> mag > INT_PART_LIMIT)
    else $error("overflow flagged below the integer part limit");

  a_result_follows_close: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> m_tvalid)
    else $error("closing request produced no result");

endmodule

`default_nettype wire
